@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker of the ring manager.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, ignored while reset is low.
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ring manager assertion failed");

// Checks a property on every rising clock edge, including during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ring manager assertion failed");

`endif

@@ hw/rtl/dbrm_pkg.sv @@
// Shared constants, codes, types and helper functions of the ring manager.
// Depends on nothing; used by every module of the block.
`default_nettype none

package dbrm_pkg;

  // Ring geometry.
  localparam int RING_BLOCKS = 5;
  localparam int BLOCK_BYTES = 524288;

  localparam int IDX_W   = $clog2(RING_BLOCKS);
  localparam int OFF_W   = $clog2(BLOCK_BYTES);
  localparam int REST_W  = OFF_W + 1;

  // Field widths of the ports.
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 4;
  localparam int COUNT_W  = 20;
  localparam int KIND_W   = 3;
  localparam int BLK_W    = 3;
  localparam int COFF_W   = 19;

  localparam int CMP_W = (REST_W > COUNT_W) ? REST_W : COUNT_W;

  // Item functions.
  localparam logic [FUNC_W-1:0] FN_RESTART = 2'd0;
  localparam logic [FUNC_W-1:0] FN_IRQ     = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ    = 2'd2;

  // Interrupt status bits.
  localparam logic [STATUS_W-1:0] ST_DATA_OK = 4'h1;
  localparam logic [STATUS_W-1:0] ST_STOPPED = 4'hE;

  // Block marks.
  typedef logic [1:0] mark_t;
  localparam mark_t MARK_FREE = 2'd0;
  localparam mark_t MARK_DMA  = 2'd1;
  localparam mark_t MARK_DATA = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] EV_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] EV_PROGRAM = 3'd1;
  localparam logic [KIND_W-1:0] EV_OVERRUN = 3'd2;
  localparam logic [KIND_W-1:0] EV_DONE    = 3'd3;
  localparam logic [KIND_W-1:0] EV_COPY    = 3'd4;
  localparam logic [KIND_W-1:0] EV_WAIT    = 3'd5;
  localparam logic [KIND_W-1:0] EV_END     = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the input item
    logic exec;  // apply the captured item and register its result
  } cmd_t;

  // Advances a ring index by a small step, wrapping at the ring size.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] ix,
                                                input logic [1:0] step);
    logic [IDX_W:0] s;
    s = {1'b0, ix} + (IDX_W+1)'(step);
    if (s >= (IDX_W+1)'(RING_BLOCKS)) begin
      s = s - (IDX_W+1)'(RING_BLOCKS);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dbrm_ctrl.sv @@
// Controller of the ring manager: input handshake, sequencing and output valid.
// Depends on dbrm_pkg; drives the datapath through a command struct.
`default_nettype none

module dbrm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output dbrm_pkg::cmd_t     cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  // The output register can take a new result when empty or being emptied.
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/dbrm_datapath.sv @@
// Datapath of the ring manager: item registers, ring state and result register.
// Depends on dbrm_pkg; steered by the command struct from dbrm_ctrl.
`default_nettype none

module dbrm_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire dbrm_pkg::cmd_t                  cmd_i,
  input  wire logic [dbrm_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [dbrm_pkg::STATUS_W-1:0]   dma_status_i,
  input  wire logic [dbrm_pkg::COUNT_W-1:0]    read_count_i,
  output logic [dbrm_pkg::KIND_W-1:0]          event_kind_o,
  output logic [dbrm_pkg::BLK_W-1:0]           block_index_o,
  output logic [dbrm_pkg::COFF_W-1:0]          copy_offset_o,
  output logic [dbrm_pkg::COUNT_W-1:0]         copy_bytes_o,
  output logic                                 capture_stopped_o
);

  // Captured item.
  logic [dbrm_pkg::FUNC_W-1:0]   func_q;
  logic [dbrm_pkg::STATUS_W-1:0] status_q;
  logic [dbrm_pkg::COUNT_W-1:0]  want_q;

  // Ring state.
  dbrm_pkg::mark_t              mark_q [dbrm_pkg::RING_BLOCKS];
  dbrm_pkg::mark_t              mark_d [dbrm_pkg::RING_BLOCKS];
  dbrm_pkg::mark_t              mark_ok [dbrm_pkg::RING_BLOCKS];
  logic [dbrm_pkg::IDX_W-1:0]   fill_q, fill_d;
  logic [dbrm_pkg::IDX_W-1:0]   drain_q, drain_d;
  logic [dbrm_pkg::OFF_W-1:0]   off_q, off_d;
  logic                         halted_q, halted_d;

  // Result being formed.
  logic [dbrm_pkg::KIND_W-1:0]  kind;
  logic [dbrm_pkg::IDX_W-1:0]   blk;
  logic [dbrm_pkg::OFF_W-1:0]   coff;
  logic [dbrm_pkg::COUNT_W-1:0] cnt;

  logic [dbrm_pkg::IDX_W-1:0]   fill_p1, fill_p2, drain_p1;
  logic                         fresh_free, drain_data;
  logic [dbrm_pkg::REST_W-1:0]  rest;
  logic [dbrm_pkg::CMP_W-1:0]   want_x, rest_x, take_x;
  logic [dbrm_pkg::CMP_W:0]     sum;

  assign fill_p1  = dbrm_pkg::ring_add(fill_q, 2'd1);
  assign fill_p2  = dbrm_pkg::ring_add(fill_q, 2'd2);
  assign drain_p1 = dbrm_pkg::ring_add(drain_q, 2'd1);

  // The drain offset always stays below the block size.
  assign rest   = dbrm_pkg::REST_W'(dbrm_pkg::BLOCK_BYTES) - {1'b0, off_q};
  assign want_x = dbrm_pkg::CMP_W'(want_q);
  assign rest_x = dbrm_pkg::CMP_W'(rest);
  assign take_x = (want_x < rest_x) ? want_x : rest_x;
  assign sum    = {1'b0, take_x} + (dbrm_pkg::CMP_W+1)'(off_q);

  // The free lookup sees the data-ok update, the drain lookup the old marks.
  always_comb begin
    fresh_free = 1'b0;
    drain_data = 1'b0;
    for (int i = 0; i < dbrm_pkg::RING_BLOCKS; i++) begin
      if (((status_q & dbrm_pkg::ST_DATA_OK) != '0)
          && (fill_q == dbrm_pkg::IDX_W'(i))) begin
        mark_ok[i] = dbrm_pkg::MARK_DATA;
      end else begin
        mark_ok[i] = mark_q[i];
      end
      if ((fill_p2 == dbrm_pkg::IDX_W'(i)) && (mark_ok[i] == dbrm_pkg::MARK_FREE)) begin
        fresh_free = 1'b1;
      end
      if ((drain_q == dbrm_pkg::IDX_W'(i)) && (mark_q[i] == dbrm_pkg::MARK_DATA)) begin
        drain_data = 1'b1;
      end
    end
  end

  always_comb begin
    mark_d   = mark_q;
    fill_d   = fill_q;
    drain_d  = drain_q;
    off_d    = off_q;
    halted_d = halted_q;
    kind     = dbrm_pkg::EV_NONE;
    blk      = '0;
    coff     = '0;
    cnt      = '0;
    case (func_q)
      dbrm_pkg::FN_RESTART: begin
        for (int i = 0; i < dbrm_pkg::RING_BLOCKS; i++) begin
          mark_d[i] = (i < 2) ? dbrm_pkg::MARK_DMA : dbrm_pkg::MARK_FREE;
        end
        fill_d   = '0;
        drain_d  = '0;
        off_d    = '0;
        halted_d = 1'b0;
      end
      dbrm_pkg::FN_IRQ: begin
        mark_d = mark_ok;
        if ((status_q & dbrm_pkg::ST_STOPPED) == '0) begin
          blk = fill_p2;
          if (fresh_free) begin
            for (int i = 0; i < dbrm_pkg::RING_BLOCKS; i++) begin
              if (fill_p2 == dbrm_pkg::IDX_W'(i)) begin
                mark_d[i] = dbrm_pkg::MARK_DMA;
              end
            end
            fill_d = fill_p1;
            kind   = dbrm_pkg::EV_PROGRAM;
          end else begin
            kind = dbrm_pkg::EV_OVERRUN;
          end
        end else begin
          halted_d = 1'b1;
          kind     = dbrm_pkg::EV_DONE;
        end
      end
      dbrm_pkg::FN_READ: begin
        if (want_q != '0) begin
          if (drain_data) begin
            kind = dbrm_pkg::EV_COPY;
            blk  = drain_q;
            coff = off_q;
            cnt  = dbrm_pkg::COUNT_W'(take_x);
            if (sum >= (dbrm_pkg::CMP_W+1)'(dbrm_pkg::BLOCK_BYTES)) begin
              // Block used up: hand it back and move on.
              off_d   = '0;
              drain_d = drain_p1;
              for (int i = 0; i < dbrm_pkg::RING_BLOCKS; i++) begin
                if (drain_q == dbrm_pkg::IDX_W'(i)) begin
                  mark_d[i] = dbrm_pkg::MARK_FREE;
                end
              end
            end else begin
              off_d = dbrm_pkg::OFF_W'(sum);
            end
          end else if (halted_q) begin
            kind = dbrm_pkg::EV_END;
          end else begin
            kind = dbrm_pkg::EV_WAIT;
          end
        end
      end
      default: begin
        kind = dbrm_pkg::EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dbrm_pkg::RING_BLOCKS; i++) begin
        mark_q[i] <= (i < 2) ? dbrm_pkg::MARK_DMA : dbrm_pkg::MARK_FREE;
      end
      fill_q   <= '0;
      drain_q  <= '0;
      off_q    <= '0;
      halted_q <= 1'b0;
    end else if (cmd_i.exec) begin
      mark_q   <= mark_d;
      fill_q   <= fill_d;
      drain_q  <= drain_d;
      off_q    <= off_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      status_q <= dma_status_i;
      want_q   <= read_count_i;
    end
    if (cmd_i.exec) begin
      event_kind_o      <= kind;
      block_index_o     <= dbrm_pkg::BLK_W'(blk);
      copy_offset_o     <= dbrm_pkg::COFF_W'(coff);
      copy_bytes_o      <= cnt;
      capture_stopped_o <= halted_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dma_block_ring_manager_top.sv @@
// Top level of the DMA block ring manager: controller plus datapath.
// Depends on dbrm_pkg, dbrm_ctrl and dbrm_datapath.
//
// The block keeps a ring of capture blocks, each free, owned by DMA or holding
// data, and gives exactly one result item for every input item: a restart, a DMA
// interrupt or a reader request. An item is captured when it is accepted and is
// applied to the ring state once the output register is free, when its result
// is written to the output register. The two-state controller takes no new item
// until the last one is applied; the next item is accepted while a result still
// waits in the output register, and is applied once that register has been
// emptied.
`default_nettype none

module dma_block_ring_manager_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [dbrm_pkg::FUNC_W-1:0]    func_i,
  input  wire logic [dbrm_pkg::STATUS_W-1:0]  dma_status_i,
  input  wire logic [dbrm_pkg::COUNT_W-1:0]   read_count_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [dbrm_pkg::KIND_W-1:0]         event_kind_o,
  output logic [dbrm_pkg::BLK_W-1:0]          block_index_o,
  output logic [dbrm_pkg::COFF_W-1:0]         copy_offset_o,
  output logic [dbrm_pkg::COUNT_W-1:0]        copy_bytes_o,
  output logic                                capture_stopped_o
);

  dbrm_pkg::cmd_t cmd;

  dbrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  dbrm_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .func_i            (func_i),
    .dma_status_i      (dma_status_i),
    .read_count_i      (read_count_i),
    .event_kind_o      (event_kind_o),
    .block_index_o     (block_index_o),
    .copy_offset_o     (copy_offset_o),
    .copy_bytes_o      (copy_bytes_o),
    .capture_stopped_o (capture_stopped_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/dbrm_checker.sv @@
// Port-level checker of the ring manager, bound to the top level below.
// Depends on dbrm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dbrm_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [dbrm_pkg::KIND_W-1:0]    event_kind_o,
  input wire logic [dbrm_pkg::BLK_W-1:0]     block_index_o,
  input wire logic [dbrm_pkg::COFF_W-1:0]    copy_offset_o,
  input wire logic [dbrm_pkg::COUNT_W-1:0]   copy_bytes_o,
  input wire logic                           capture_stopped_o
);

  // A result that is held back keeps its kind, block index and byte count.
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o) && $stable(copy_bytes_o) && $stable(block_index_o))

  // A stopping interrupt always reports the stopped flag with it.
  `ASSERT_CLKD(a_done_stopped, clk_i, rst_ni, out_valid_o && event_kind_o == dbrm_pkg::EV_DONE |-> capture_stopped_o)

  // A wait is only given while capture is still running.
  `ASSERT_CLKD(a_wait_running, clk_i, rst_ni, out_valid_o && event_kind_o == dbrm_pkg::EV_WAIT |-> !capture_stopped_o)

  // A copy moves at least one byte from a block inside the ring.
  `ASSERT_CLKD(a_copy_sane, clk_i, rst_ni, out_valid_o && event_kind_o == dbrm_pkg::EV_COPY |-> copy_bytes_o != '0 && block_index_o < dbrm_pkg::BLK_W'(dbrm_pkg::RING_BLOCKS))

  // Results other than a copy carry no offset or count.
  `ASSERT_CLKD(a_nocopy_zero, clk_i, rst_ni, out_valid_o && event_kind_o != dbrm_pkg::EV_COPY |-> copy_bytes_o == '0 && copy_offset_o == '0)

endmodule

bind dma_block_ring_manager_top dbrm_checker u_dbrm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .event_kind_o      (event_kind_o),
  .block_index_o     (block_index_o),
  .copy_offset_o     (copy_offset_o),
  .copy_bytes_o      (copy_bytes_o),
  .capture_stopped_o (capture_stopped_o)
);

`default_nettype wire

@@ tb/dbrm_ring_checker.sv @@
// Checker for the DMA block ring manager: watches both item channels, predicts each result
// from its own copy of the ring state and compares it field by field with the block's output.
// Depends on dbrm_pkg for widths, ring geometry and the status, mark and result codes.

module dbrm_ring_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [dbrm_pkg::FUNC_W-1:0]   func_i,
  input  logic [dbrm_pkg::STATUS_W-1:0] dma_status_i,
  input  logic [dbrm_pkg::COUNT_W-1:0]  read_count_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [dbrm_pkg::KIND_W-1:0]   event_kind_i,
  input  logic [dbrm_pkg::BLK_W-1:0]    block_index_i,
  input  logic [dbrm_pkg::COFF_W-1:0]   copy_offset_i,
  input  logic [dbrm_pkg::COUNT_W-1:0]  copy_bytes_i,
  input  logic                          capture_stopped_i,
  output int                            errors_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dbrm_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BLK_W-1:0]   blk;
    logic [COFF_W-1:0]  off;
    logic [COUNT_W-1:0] cnt;
    logic               stopped;
  } ring_result_t;

  mark_t        ring_mark [RING_BLOCKS];
  int           fill_ix;
  int           drain_ix;
  int           drain_pos;
  logic         halted;
  ring_result_t expected_results [$];

  function automatic void clear_ring();
    for (int i = 0; i < RING_BLOCKS; i++) begin
      ring_mark[i] = MARK_FREE;
    end
    ring_mark[0] = MARK_DMA;
    ring_mark[1] = MARK_DMA;
    fill_ix   = 0;
    drain_ix  = 0;
    drain_pos = 0;
    halted    = 1'b0;
  endfunction

  // Applies one input item to the ring and returns the result it should give.
  function automatic ring_result_t apply_item(input logic [FUNC_W-1:0]   fn,
                                              input logic [STATUS_W-1:0] st,
                                              input logic [COUNT_W-1:0]  want);
    ring_result_t res;
    int           want_n;
    int           fresh;
    int           rest;
    int           take;
    res    = '0;
    want_n = want;
    case (fn)
      FN_RESTART: begin
        clear_ring();
      end
      FN_IRQ: begin
        if ((st & ST_DATA_OK) != '0) begin
          ring_mark[fill_ix] = MARK_DATA;
        end
        if ((st & ST_STOPPED) == '0) begin
          fresh   = (fill_ix + 2) % RING_BLOCKS;
          res.blk = BLK_W'(fresh);
          if (ring_mark[fresh] == MARK_FREE) begin
            ring_mark[fresh] = MARK_DMA;
            fill_ix  = (fill_ix + 1) % RING_BLOCKS;
            res.kind = EV_PROGRAM;
          end else begin
            res.kind = EV_OVERRUN;
          end
        end else begin
          halted   = 1'b1;
          res.kind = EV_DONE;
        end
      end
      FN_READ: begin
        if (want_n != 0) begin
          if (ring_mark[drain_ix] == MARK_DATA) begin
            rest = (drain_pos < BLOCK_BYTES) ? BLOCK_BYTES - drain_pos : 0;
            take = (want_n < rest) ? want_n : rest;
            res.kind = EV_COPY;
            res.blk  = BLK_W'(drain_ix);
            res.off  = COFF_W'(drain_pos);
            res.cnt  = COUNT_W'(take);
            drain_pos = drain_pos + take;
            // A block read to its end goes back to the free pool.
            if (drain_pos >= BLOCK_BYTES) begin
              ring_mark[drain_ix] = MARK_FREE;
              drain_pos = 0;
              drain_ix  = (drain_ix + 1) % RING_BLOCKS;
            end
          end else if (halted) begin
            res.kind = EV_END;
          end else begin
            res.kind = EV_WAIT;
          end
        end
      end
      default: begin
      end
    endcase
    res.stopped = halted;
    return res;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ring_result_t exp_r;
    if (!rst_ni) begin
      clear_ring();
      expected_results.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // The result of an item never leaves on the edge that accepts it, so compare first.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          errors_o++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("event_kind", exp_r.kind, event_kind_i);
          check_field("block_index", exp_r.blk, block_index_i);
          check_field("copy_offset", exp_r.off, copy_offset_i);
          check_field("copy_bytes", exp_r.cnt, copy_bytes_i);
          check_field("capture_stopped", exp_r.stopped, capture_stopped_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(apply_item(func_i, dma_status_i, read_count_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ tb/dma_block_ring_manager_top_tb.sv @@
// Top of the ring manager testbench: clock, reset, directed and random items on the input
// channel, random back-pressure on the result channel, and the final verdict.
// Depends on dbrm_pkg, dma_block_ring_manager_top and dbrm_ring_checker.

module dma_block_ring_manager_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbrm_pkg::*;

  localparam logic [FUNC_W-1:0]  FN_SPARE    = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT = COUNT_W'(BLOCK_BYTES);
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 300000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   func;
  logic [STATUS_W-1:0] dma_status;
  logic [COUNT_W-1:0]  read_count;
  logic                out_valid;
  logic                out_ready;
  logic [KIND_W-1:0]   event_kind;
  logic [BLK_W-1:0]    block_index;
  logic [COFF_W-1:0]   copy_offset;
  logic [COUNT_W-1:0]  copy_bytes;
  logic                capture_stopped;
  int                  errors;
  int                  pending;
  int                  cycle_count = 0;
  int                  items_sent  = 0;
  bit                  sender_busy = 1'b0;

  dma_block_ring_manager_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (func),
    .dma_status_i     (dma_status),
    .read_count_i     (read_count),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .event_kind_o     (event_kind),
    .block_index_o    (block_index),
    .copy_offset_o    (copy_offset),
    .copy_bytes_o     (copy_bytes),
    .capture_stopped_o(capture_stopped)
  );

  dbrm_ring_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .func_i           (func),
    .dma_status_i     (dma_status),
    .read_count_i     (read_count),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .event_kind_i     (event_kind),
    .block_index_i    (block_index),
    .copy_offset_i    (copy_offset),
    .copy_bytes_i     (copy_bytes),
    .capture_stopped_i(capture_stopped),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[dma_block_ring_manager_top] ERROR");
      $finish;
    end
  end

  // Waits a drawn number of cycles, then offers the item until it is accepted.
  // Every 40 items the sender may switch to a stretch with no gaps at all.
  task automatic send_item(input logic [FUNC_W-1:0]   fn,
                           input logic [STATUS_W-1:0] st,
                           input logic [COUNT_W-1:0]  cnt);
    int gap;
    gap = sender_busy ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    dma_status <= st;
    read_count <= cnt;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
    if (items_sent % 40 == 0) begin
      sender_busy = ($urandom_range(0, 3) == 0);
    end
  endtask

  // Mostly interrupts with data and reads large enough to drain blocks, so the ring keeps
  // turning; restarts, the spare selector and stopping interrupts are sprinkled in.
  task automatic send_random_item();
    int                  pick;
    int                  sub;
    logic [STATUS_W-1:0] st;
    logic [COUNT_W-1:0]  cnt;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    st   = STATUS_W'($urandom_range(0, 15));
    cnt  = COUNT_W'($urandom_range(0, 1048575));
    if (pick < 2) begin
      send_item(FN_RESTART, st, cnt);
    end else if (pick < 4) begin
      send_item(FN_SPARE, st, cnt);
    end else if (pick < 46) begin
      if (sub < 85) begin
        st = ST_DATA_OK;
      end else if (sub < 92) begin
        st = '0;
      end
      send_item(FN_IRQ, st, cnt);
    end else begin
      if (sub < 5) begin
        cnt = '0;
      end else if (sub < 50) begin
        cnt = COUNT_W'($urandom_range(262144, 1048575));
      end else if (sub < 80) begin
        cnt = COUNT_W'($urandom_range(1, 65535));
      end
      send_item(FN_READ, st, cnt);
    end
  endtask

  initial begin
    int  stall;
    int  taken;
    bit  steady;
    taken  = 0;
    steady = 1'b0;
    out_ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      taken++;
      if (taken % 40 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    func       <= FN_RESTART;
    dma_status <= '0;
    read_count <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fresh ring: nothing to read yet, an empty read, the spare selector, an interrupt
    // without data, and a restart carrying junk in its other fields.
    send_item(FN_READ, '0, 20'd5);
    send_item(FN_READ, '1, '0);
    send_item(FN_SPARE, '1, COUNT_MAX);
    send_item(FN_IRQ, '0, COUNT_MAX);
    send_item(FN_RESTART, '1, COUNT_MAX);
    // Fill block 0, read one byte, then read the rest with the largest request.
    send_item(FN_IRQ, ST_DATA_OK, '0);
    send_item(FN_READ, '0, 20'd1);
    send_item(FN_READ, '0, COUNT_MAX);
    // Run the fill index round the ring until the block two ahead is still full.
    send_item(FN_IRQ, ST_DATA_OK, '0);
    send_item(FN_IRQ, ST_DATA_OK, '0);
    send_item(FN_IRQ, ST_DATA_OK, '0);
    send_item(FN_IRQ, ST_DATA_OK, '0);
    send_item(FN_READ, '0, BLOCK_COUNT);
    send_item(FN_IRQ, ST_DATA_OK, '0);
    // Stop with data, then drain everything: copies go on while halted, then end of data.
    send_item(FN_IRQ, ST_DATA_OK | ST_STOPPED, '0);
    repeat (5) send_item(FN_READ, '0, COUNT_MAX);
    send_item(FN_READ, '0, '0);
    send_item(FN_IRQ, ST_STOPPED, '0);
    send_item(FN_IRQ, ST_DATA_OK, '0);
    send_item(FN_RESTART, '0, '0);
    send_item(FN_READ, '0, 20'd7);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_random_item();
    end
    in_valid <= 1'b0;

    // The checker counts the last item on the edge that accepted it, so the count is read only after that edge.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[dma_block_ring_manager_top] OK");
    end else begin
      $display("[dma_block_ring_manager_top] ERROR");
    end
    $finish;
  end

endmodule
